@@ hw/rtl/fpd_pkg.sv @@
// Shared types and constants for the binary64 divider.
package fpd_pkg;

  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;
  localparam logic [10:0] EXP_ALL1    = 11'h7FF;
  localparam int          EXP_BIAS    = 1023;
  localparam int          QBITS       = 54;
  localparam int          CNT_W       = $clog2(QBITS);
  localparam int          EXP_W       = 13;

  typedef struct packed {
    logic load;
    logic norm;
    logic align;
    logic div;
    logic round;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic div_last;
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NORM  = 6'b000010,
    S_ALIGN = 6'b000100,
    S_DIV   = 6'b001000,
    S_ROUND = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

@@ hw/rtl/fpd_ctrl.sv @@
// Sequencer for the binary64 divider: load, normalize, align, divide, round, hand off.
module fpd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fpd_pkg::status_t status,
  output fpd_pkg::cmd_t    cmd
);
  import fpd_pkg::*;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (status.special) begin
          state_next = S_DONE;
        end else if (status.norm_done) begin
          state_next = S_ALIGN;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ hw/rtl/fpd_dp.sv @@
// Datapath for the binary64 divider: operand registers, restoring divide, rounding.
module fpd_dp (
  input  logic             clk,
  input  logic [63:0]      dividend,
  input  logic [63:0]      divisor,
  input  fpd_pkg::cmd_t    cmd,
  output fpd_pkg::status_t status,
  output logic [63:0]      quotient
);
  import fpd_pkg::*;

  logic [QBITS-1:0]        am;
  logic [QBITS-2:0]        bm;
  logic signed [EXP_W-1:0] ea, eb;
  logic [QBITS-1:0]        q;
  logic [CNT_W-1:0]        cnt;
  logic                    sign;
  logic                    special;
  logic [63:0]             result;

  logic [10:0] xa, xb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s_in;
  logic [63:0] spec_val;
  logic        spec_hit;

  always_comb begin
    xa     = dividend[62:52];
    xb     = divisor[62:52];
    s_in   = dividend[63] ^ divisor[63];
    a_nan  = (xa == EXP_ALL1) && (dividend[51:0] != '0);
    b_nan  = (xb == EXP_ALL1) && (divisor[51:0] != '0);
    a_inf  = (xa == EXP_ALL1) && (dividend[51:0] == '0);
    b_inf  = (xb == EXP_ALL1) && (divisor[51:0] == '0);
    a_zero = (xa == '0) && (dividend[51:0] == '0);
    b_zero = (xb == '0) && (divisor[51:0] == '0);
    spec_hit = 1'b1;
    if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
      spec_val = DEFAULT_NAN;
    end else if (b_zero || a_inf) begin
      spec_val = {s_in, EXP_ALL1, 52'd0};
    end else if (a_zero || b_inf) begin
      spec_val = {s_in, 63'd0};
    end else begin
      spec_val = '0;
      spec_hit = 1'b0;
    end
  end

  // trial subtraction
  logic             ge;
  logic [QBITS-1:0] diff, rem;
  assign ge   = (am >= {1'b0, bm});
  assign diff = am - {1'b0, bm};
  assign rem  = ge ? diff : am;

  // rounding and exponent range
  logic                    sticky, guard, inc;
  logic [QBITS-1:0]        qr;
  logic signed [EXP_W-1:0] e;
  logic [63:0]             fin;
  always_comb begin
    sticky = ge || (am != '0);
    guard  = q[0];
    inc    = guard && (sticky || q[1]);
    qr     = {1'b0, q[QBITS-1:1]} + {{(QBITS-1){1'b0}}, inc};
    e      = ea - eb + EXP_W'(EXP_BIAS);
    if (qr[QBITS-1]) begin
      qr = qr >> 1;
      e  = e + EXP_W'(1);
    end
    if (e <= 0) begin
      fin = {sign, 63'd0};
    end else if (e >= $signed({2'b00, EXP_ALL1})) begin
      fin = {sign, EXP_ALL1, 52'd0};
    end else begin
      fin = {sign, e[10:0], qr[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      am      <= {1'b0, (xa != '0), dividend[51:0]};
      bm      <= {(xb != '0), divisor[51:0]};
      ea      <= (xa != '0) ? $signed({2'b00, xa}) : EXP_W'(1);
      eb      <= (xb != '0) ? $signed({2'b00, xb}) : EXP_W'(1);
      sign    <= s_in;
      special <= spec_hit;
      result  <= spec_val;
      cnt     <= '0;
      q       <= '0;
    end
    if (cmd.norm) begin
      if (!am[52]) begin
        am <= am << 1;
        ea <= ea - EXP_W'(1);
      end
      if (!bm[52]) begin
        bm <= bm << 1;
        eb <= eb - EXP_W'(1);
      end
    end
    if (cmd.align && !ge) begin
      am <= am << 1;
      ea <= ea - EXP_W'(1);
    end
    if (cmd.div) begin
      q   <= {q[QBITS-2:0], ge};
      am  <= rem << 1;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.round) result <= fin;
  end

  assign status.special   = special;
  assign status.norm_done = am[52] && bm[52];
  assign status.div_last  = (cnt == CNT_W'(QBITS - 1));
  assign quotient         = result;

endmodule

@@ hw/rtl/fp64_divider.sv @@
// Top level of the binary64 divider.
//
// Request channel: in_valid/in_ready carry dividend and divisor (binary64
// bit patterns). Result channel: out_valid/out_ready carry quotient,
// rounded to nearest even; subnormal results flush to signed zero.
// One request is worked on at a time. in_ready is high only while idle.
// Operands are loaded at the accepting edge.
// Special operands (NaN, zero, infinity) go from normalize straight to done.
// Other operands pass through normalize, where each subnormal significand
// (up to 52 leading zeros; normals need no shift) is shifted left, both
// together, until its leading bit is set; then align, divide and round
// follow before out_valid. The restoring loop forms one quotient bit per
// cycle in a single subtractor.
// The result register holds quotient while the receiver stalls; the next
// request is taken the cycle after the result is accepted.
// Reset clears the sequencer: no result is pending after reset.
module fp64_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] quotient
);
  import fpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  fpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpd_dp u_dp (
    .clk      (clk),
    .dividend (dividend),
    .divisor  (divisor),
    .cmd      (cmd),
    .status   (status),
    .quotient (quotient)
  );

endmodule

@@ hw/rtl/fpd_chk.sv @@
// Port-level checker for the binary64 divider, bound to the top level.
module fpd_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] quotient
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  a_acc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in cycle after request");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind fp64_divider fpd_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .quotient  (quotient)
);
